@@ rtl/jtp_pkg.sv @@
`default_nettype none

package jtp_pkg;

	// structural defaults
	localparam int JOINTS_DEFAULT    = 7;
	localparam int FRAC_BITS_DEFAULT = 16;

	// datapath widths
	localparam int MUL_W = 33;
	localparam int ACC_W = 66;

	// item kinds
	localparam logic [1:0] KIND_LOAD_GAINS = 2'd0;
	localparam logic [1:0] KIND_START      = 2'd1;
	localparam logic [1:0] KIND_STEP       = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_CORIOLIS_SCALE  = 2'd0;
	localparam logic [1:0] CFG_MAX_TORQUE_STEP = 2'd1;
	localparam logic [1:0] CFG_VEL_FILT_WEIGHT = 2'd2;

	// configuration reset values
	localparam logic signed [31:0] CORIOLIS_SCALE_RESET  = 32'sd65536;
	localparam logic [30:0]        MAX_TORQUE_STEP_RESET = 31'd65536;
	localparam logic [16:0]        VEL_FILT_WEIGHT_RESET = 17'd64881;

	// saturation bounds at accumulator width
	localparam logic signed [ACC_W-1:0] S32_MAX_W = 66'sd2147483647;
	localparam logic signed [ACC_W-1:0] S32_MIN_W = -66'sd2147483648;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         joint;
		logic signed [31:0] measured_position;
		logic signed [31:0] measured_velocity;
		logic signed [31:0] velocity_ref;
		logic signed [31:0] coriolis_torque;
		logic signed [31:0] previous_torque;
		logic [16:0]        step_period;
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_d;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         out_joint;
		logic signed [31:0] torque_command;
		logic               rate_limited;
	} rsp_t;

	// one word of per-joint state
	typedef struct packed {
		logic signed [31:0] desired_position;
		logic signed [31:0] filtered_velocity;
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_d;
	} entry_t;

	function automatic logic signed [ACC_W-1:0] sext32(input logic signed [31:0] x);
		return {{(ACC_W-32){x[31]}}, x};
	endfunction

	function automatic logic signed [MUL_W-1:0] mop32(input logic signed [31:0] x);
		return {x[31], x};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX_W) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN_W) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/joint_torque_pd_rate_limit_unit.sv @@
`default_nettype none

// Per-joint PD torque controller with a torque rate limit, in signed fixed point
// with FRAC_BITS fraction bits. Each cmd transaction names one joint and either loads
// its gains, captures the measured position as the desired position, or runs a
// control step that filters the velocity, integrates the velocity reference and
// returns one rate-limited torque on rsp. Items are handled one at a time, with
// cmd_stall high from an item's acceptance until the block is idle again: a
// control step runs through the READ, MUL_W, MUL_VREF, FILT, POS, ERR, MUL_KP,
// TERM_D, TERM_P, SUM and LIMIT states, and a load or start through READ alone.
// An item for a joint at or above JOINTS or of the unused kind is taken and
// dropped. The control step length comes from its chain of six products
// through one shared multiplier and the per-joint read-modify-write of the
// state memory; a result waiting on rsp_stall holds the step in LIMIT. Joint
// state is zero after reset without a clearing pass. Configuration is always
// ready and must be written while the block is idle.
module joint_torque_pd_rate_limit_unit #(
	parameter int JOINTS    = jtp_pkg::JOINTS_DEFAULT,
	parameter int FRAC_BITS = jtp_pkg::FRAC_BITS_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_stall,
	input  wire jtp_pkg::cmd_t cmd,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output jtp_pkg::rsp_t     rsp,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam logic signed [jtp_pkg::MUL_W-1:0] ONE =
		jtp_pkg::MUL_W'(33'sd1 <<< FRAC_BITS);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_READ     = 12'b0000_0000_0010,
		ST_MUL_W    = 12'b0000_0000_0100,
		ST_MUL_VREF = 12'b0000_0000_1000,
		ST_FILT     = 12'b0000_0001_0000,
		ST_POS      = 12'b0000_0010_0000,
		ST_ERR      = 12'b0000_0100_0000,
		ST_MUL_KP   = 12'b0000_1000_0000,
		ST_TERM_D   = 12'b0001_0000_0000,
		ST_TERM_P   = 12'b0010_0000_0000,
		ST_SUM      = 12'b0100_0000_0000,
		ST_LIMIT    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// configuration registers
	logic signed [31:0] coriolis_scale_q;
	logic [30:0]        max_torque_step_q;
	logic [16:0]        vel_filt_weight_q;

	jtp_pkg::cmd_t      item_q;
	jtp_pkg::rsp_t      rsp_q;
	logic               rsp_valid_q;

	// intermediate results of a control step
	logic signed [31:0] fvn_q;
	logic signed [31:0] dpn_q;
	logic signed [31:0] ev_q;
	logic signed [31:0] ep_q;
	logic signed [31:0] cor_q;
	logic signed [31:0] td_q;
	logic signed [31:0] tp_q;
	logic signed [31:0] tau_q;

	logic               cmd_fire;
	logic               item_ok;
	logic [AW-1:0]      item_addr;
	logic               rsp_load;

	jtp_pkg::entry_t    rd_entry;
	jtp_pkg::entry_t    wr_entry;
	logic               mem_wr_en;

	logic signed [jtp_pkg::MUL_W-1:0] mul_a;
	logic signed [jtp_pkg::MUL_W-1:0] mul_b;
	logic                             accumulate;
	logic signed [31:0]               mac_result;
	logic signed [jtp_pkg::MUL_W-1:0] weight_ext;

	// rate limit terms
	logic signed [jtp_pkg::ACC_W-1:0] diff;
	logic signed [jtp_pkg::ACC_W-1:0] max_ext;
	logic signed [31:0]               cmd_torque;
	logic                             limited;

	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign item_ok   = (32'(cmd.joint) < 32'(JOINTS)) && (cmd.kind != 2'd3);
	assign item_addr = AW'({{AW{1'b0}}, item_q.joint});
	assign rsp_load  = (state_q == ST_LIMIT) && (!rsp_valid_q || !rsp_stall);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	jtp_state_mem #(
		.JOINTS (JOINTS),
		.AW     (AW)
	) u_state_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (cmd_fire && item_ok),
		.rd_addr  (AW'({{AW{1'b0}}, cmd.joint})),
		.rd_entry (rd_entry),
		.wr_en    (mem_wr_en),
		.wr_addr  (item_addr),
		.wr_entry (wr_entry)
	);

	jtp_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk        (clk),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.accumulate (accumulate),
		.result     (mac_result)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coriolis_scale_q  <= jtp_pkg::CORIOLIS_SCALE_RESET;
			max_torque_step_q <= jtp_pkg::MAX_TORQUE_STEP_RESET;
			vel_filt_weight_q <= jtp_pkg::VEL_FILT_WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jtp_pkg::CFG_CORIOLIS_SCALE: begin
					coriolis_scale_q <= cfg_data;
				end
				jtp_pkg::CFG_MAX_TORQUE_STEP: begin
					max_torque_step_q <= cfg_data[30:0];
				end
				jtp_pkg::CFG_VEL_FILT_WEIGHT: begin
					vel_filt_weight_q <= cfg_data[16:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && item_ok) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = (item_q.kind == jtp_pkg::KIND_STEP) ? ST_MUL_W : ST_IDLE;
			end
			ST_MUL_W:    state_d = ST_MUL_VREF;
			ST_MUL_VREF: state_d = ST_FILT;
			ST_FILT:     state_d = ST_POS;
			ST_POS:      state_d = ST_ERR;
			ST_ERR:      state_d = ST_MUL_KP;
			ST_MUL_KP:   state_d = ST_TERM_D;
			ST_TERM_D:   state_d = ST_TERM_P;
			ST_TERM_P:   state_d = ST_SUM;
			ST_SUM:      state_d = ST_LIMIT;
			ST_LIMIT: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// multiplier operand selection
	assign weight_ext = signed'({16'd0, vel_filt_weight_q});

	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		accumulate = 1'b0;
		case (state_q)
			ST_READ: begin
				mul_a = ONE - weight_ext;
				mul_b = jtp_pkg::mop32(rd_entry.filtered_velocity);
			end
			ST_MUL_W: begin
				mul_a = weight_ext;
				mul_b = jtp_pkg::mop32(item_q.measured_velocity);
			end
			ST_MUL_VREF: begin
				mul_a      = jtp_pkg::mop32(item_q.velocity_ref);
				mul_b      = signed'({16'd0, item_q.step_period});
				accumulate = 1'b1;
			end
			ST_FILT: begin
				mul_a = jtp_pkg::mop32(coriolis_scale_q);
				mul_b = jtp_pkg::mop32(item_q.coriolis_torque);
			end
			ST_ERR: begin
				mul_a = jtp_pkg::mop32(rd_entry.gain_d);
				mul_b = jtp_pkg::mop32(ev_q);
			end
			ST_MUL_KP: begin
				mul_a = jtp_pkg::mop32(rd_entry.gain_p);
				mul_b = jtp_pkg::mop32(ep_q);
			end
			default: begin
			end
		endcase
	end

	// step limit against the previous torque
	always_comb begin
		diff    = jtp_pkg::sext32(tau_q) - jtp_pkg::sext32(item_q.previous_torque);
		max_ext = signed'({35'd0, max_torque_step_q});
		if (diff > max_ext) begin
			cmd_torque = jtp_pkg::sat32(jtp_pkg::sext32(item_q.previous_torque) + max_ext);
			limited    = 1'b1;
		end else if (diff < -max_ext) begin
			cmd_torque = jtp_pkg::sat32(jtp_pkg::sext32(item_q.previous_torque) - max_ext);
			limited    = 1'b1;
		end else begin
			cmd_torque = tau_q;
			limited    = 1'b0;
		end
	end

	// write-back of the joint state
	always_comb begin
		wr_entry  = rd_entry;
		mem_wr_en = 1'b0;
		case (state_q)
			ST_READ: begin
				if (item_q.kind == jtp_pkg::KIND_LOAD_GAINS) begin
					wr_entry.gain_p = item_q.gain_p;
					wr_entry.gain_d = item_q.gain_d;
					mem_wr_en       = 1'b1;
				end else if (item_q.kind == jtp_pkg::KIND_START) begin
					wr_entry.desired_position = item_q.measured_position;
					mem_wr_en                 = 1'b1;
				end
			end
			ST_LIMIT: begin
				wr_entry.desired_position  = dpn_q;
				wr_entry.filtered_velocity = fvn_q;
				mem_wr_en                  = rsp_load;
			end
			default: begin
			end
		endcase
	end

	// item capture and step datapath registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			item_q <= cmd;
		end
		case (state_q)
			ST_FILT: begin
				fvn_q <= mac_result;
			end
			ST_POS: begin
				dpn_q <= jtp_pkg::sat32(jtp_pkg::sext32(rd_entry.desired_position)
					+ jtp_pkg::sext32(mac_result));
				ev_q  <= jtp_pkg::sat32(jtp_pkg::sext32(item_q.velocity_ref)
					- jtp_pkg::sext32(fvn_q));
			end
			ST_ERR: begin
				ep_q  <= jtp_pkg::sat32(jtp_pkg::sext32(dpn_q)
					- jtp_pkg::sext32(item_q.measured_position));
				cor_q <= mac_result;
			end
			ST_TERM_D: begin
				td_q <= mac_result;
			end
			ST_TERM_P: begin
				tp_q <= mac_result;
			end
			ST_SUM: begin
				tau_q <= jtp_pkg::sat32(jtp_pkg::sext32(cor_q) + jtp_pkg::sext32(td_q)
					+ jtp_pkg::sext32(tp_q));
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.out_joint      <= item_q.joint;
			rsp_q.torque_command <= cmd_torque;
			rsp_q.rate_limited   <= limited;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// a new result only ever comes out of the limit stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_LIMIT))
		else $error("result raised outside the limit stage");

	// state is written back only by the read or the limit stage
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (state_q == ST_READ || state_q == ST_LIMIT))
		else $error("state write outside read or limit stage");

	// an accepted item for a real joint and kind starts a memory read
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && item_ok) |=> (state_q == ST_READ))
		else $error("accepted item did not start a read");

	// an unlimited result carries the summed torque unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && !limited) |=> (rsp.torque_command == $past(tau_q)))
		else $error("unlimited torque differs from the sum");

	// a limited command carries the limit flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && limited) |=> rsp.rate_limited)
		else $error("limit flag lost");

endmodule

`default_nettype wire

@@ rtl/jtp_mac.sv @@
`default_nettype none

module jtp_mac #(
	parameter int FRAC_BITS = jtp_pkg::FRAC_BITS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic signed [jtp_pkg::MUL_W-1:0]    mul_a,
	input  wire logic signed [jtp_pkg::MUL_W-1:0]    mul_b,
	input  wire logic                                accumulate,
	output logic signed [31:0]                       result
);

	localparam logic signed [jtp_pkg::ACC_W-1:0] HALF =
		jtp_pkg::ACC_W'(66'sd1 <<< (FRAC_BITS - 1));

	logic signed [jtp_pkg::ACC_W-1:0] prod_s1;
	logic signed [jtp_pkg::ACC_W-1:0] acc_s2;
	logic signed [jtp_pkg::ACC_W-1:0] biased;
	logic signed [jtp_pkg::ACC_W-1:0] scaled;

	// product register, then load or accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (accumulate) begin
			acc_s2 <= acc_s2 + prod_s1;
		end else begin
			acc_s2 <= prod_s1;
		end
	end

	// round half up to the fraction width and saturate
	always_comb begin
		biased = acc_s2 + HALF;
		scaled = biased >>> FRAC_BITS;
		result = jtp_pkg::sat32(scaled);
	end

endmodule

`default_nettype wire

@@ rtl/jtp_state_mem.sv @@
`default_nettype none

module jtp_state_mem #(
	parameter int JOINTS = jtp_pkg::JOINTS_DEFAULT,
	parameter int AW     = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output jtp_pkg::entry_t      rd_entry,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire jtp_pkg::entry_t wr_entry
);

	jtp_pkg::entry_t   mem_q [JOINTS];
	jtp_pkg::entry_t   rd_data_q;
	logic [JOINTS-1:0] written_q;
	logic              rd_hit_q;

	// storage array with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// per-joint written flags, so unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire
